FILE: rtl/core/lfsrsf_pkg.sv
// ----------------------------------------------------------------------------
// lfsrsf_pkg
// Types, constants and colour decode shared by the starfield generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsrsf_pkg;

   localparam int unsigned STAR_ADDR_W = 17;
   localparam int unsigned ORIGIN_W    = 18;
   localparam int unsigned ENTRY_W     = 7;

   localparam logic [STAR_ADDR_W-1:0] STAR_PERIOD  = 17'h1ffff;
   localparam logic [STAR_ADDR_W-1:0] STAR_LAST    = 17'h1fffe;
   localparam logic [ORIGIN_W-1:0]    ORIGIN_MOD   = 18'd262142;
   localparam logic [STAR_ADDR_W-1:0] ENABLE_MASK  = 17'h1fe01;
   localparam logic [STAR_ADDR_W-1:0] ENABLE_MATCH = 17'h1fe00;
   localparam logic [31:0]            ALPHA_OPAQUE = 32'hff000000;
   localparam logic [5:0]             FRAME_LAST   = 6'd63;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FRAME = 1'b1
   } opcode_type;

   typedef struct packed {
      logic                   en;
      logic [STAR_ADDR_W-1:0] addr;
   } rd_req_type;

   function automatic logic [7:0] level_of(input logic [1:0] code);
      logic [7:0] lvl;
      case (code)
         2'd0:    lvl = 8'd0;
         2'd1:    lvl = 8'd194;
         2'd2:    lvl = 8'd214;
         2'd3:    lvl = 8'd255;
         default: lvl = 8'd0;
      endcase
      return lvl;
   endfunction

   function automatic logic [31:0] colour_of(input logic [5:0] c);
      return ALPHA_OPAQUE
           | {8'd0, level_of({c[4], c[5]}), 16'd0}
           | {16'd0, level_of({c[2], c[3]}), 8'd0}
           | {24'd0, level_of({c[0], c[1]})};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lfsrsf_channels.sv
// ----------------------------------------------------------------------------
// lfsrsf channels
// Valid/ready channel interfaces for pixel requests and pixel responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfsrsf_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [7:0]  pixel_x;
   logic [7:0]  pixel_y;
   logic [2:0]  scroll_mode;
   logic [17:0] reseed_value;

   modport source (output valid, opcode, pixel_x, pixel_y, scroll_mode, reseed_value,
                   input ready);
   modport sink   (input valid, opcode, pixel_x, pixel_y, scroll_mode, reseed_value,
                   output ready);
endinterface

interface lfsrsf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_argb;
   logic        star_visible;

   modport source (output valid, pixel_argb, star_visible, input ready);
   modport sink   (input valid, pixel_argb, star_visible, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lfsrsf_star_table.sv
// ----------------------------------------------------------------------------
// lfsrsf_star_table
// Star entry memory, filled by an LFSR walk after reset, then read-only.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsrsf_star_table (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire lfsrsf_pkg::rd_req_type                  rd_req,
   output logic     [lfsrsf_pkg::ENTRY_W-1:0]           rd_data,
   output logic                                         fill_done
);
   import lfsrsf_pkg::*;

   logic [ENTRY_W-1:0]     mem [STAR_PERIOD];
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   fill_busy_ff, fill_busy_in;
   logic [STAR_ADDR_W-1:0] fill_idx_ff, fill_idx_in;
   logic [STAR_ADDR_W-1:0] lfsr_ff, lfsr_in;
   logic [ENTRY_W-1:0]     fill_entry;

   always_comb begin
      fill_entry   = {((lfsr_ff & ENABLE_MASK) == ENABLE_MATCH), ~lfsr_ff[8:3]};
      lfsr_in      = {lfsr_ff[12] ^ ~lfsr_ff[0], lfsr_ff[STAR_ADDR_W-1:1]};
      fill_idx_in  = fill_idx_ff + 1'b1;
      fill_busy_in = fill_busy_ff && (fill_idx_ff != STAR_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_busy_ff <= 1'b1;
         fill_idx_ff  <= '0;
         lfsr_ff      <= '0;
      end else if (fill_busy_ff) begin
         fill_busy_ff <= fill_busy_in;
         fill_idx_ff  <= fill_idx_in;
         lfsr_ff      <= lfsr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_busy_ff) begin
         mem[fill_idx_ff] <= fill_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_req.addr];
      end
   end

   assign rd_data   = rd_data_ff;
   assign fill_done = !fill_busy_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lfsr_starfield_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// lfsr_starfield_pixel_generator_unit
// Scrolling starfield pixel source: address, star table read, colour decode.
// ----------------------------------------------------------------------------
// Response valid rises once a request has passed the address stage, star table
// read and output register. Throughput: one item per cycle while the response
// side does not hold rsp_ch.ready low, limited by the single read port of the
// star table.
// Reset: origin and frame count clear; the star table is then filled by an LFSR
// walk over all 131071 entries, during which req_ch.ready stays low.
`default_nettype none

module lfsr_starfield_pixel_generator_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   lfsrsf_req_if.sink   req_ch,
   lfsrsf_rsp_if.source rsp_ch
);
   import lfsrsf_pkg::*;

   logic                   fill_done;
   rd_req_type             rd_req;
   logic [ENTRY_W-1:0]     rd_data;

   logic [ORIGIN_W-1:0]    origin_ff, origin_in;
   logic [5:0]             frame_ff, frame_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic [STAR_ADDR_W-1:0] s1_addr_ff;
   logic                   s1_frame_ff;
   logic                   s1_par_ff;

   logic                   s2_valid_ff, s2_valid_in;
   logic                   s2_frame_ff;
   logic                   s2_par_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [31:0]            out_argb_ff;
   logic                   out_vis_ff;

   logic                   s1_ready, s2_ready, out_ready;
   logic                   req_xfer, s1_move, s2_move;
   logic                   is_frame;
   logic [ORIGIN_W:0]      step_sum;
   logic [ORIGIN_W-1:0]    stepped, reseeded;
   logic [ORIGIN_W-1:0]    addr_sum;
   logic [STAR_ADDR_W-1:0] addr_mod;
   logic                   star_hit;

   lfsrsf_star_table u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_req    (rd_req),
      .rd_data   (rd_data),
      .fill_done (fill_done)
   );

   always_comb begin
      out_ready = !out_valid_ff || rsp_ch.ready;
      s2_ready  = !s2_valid_ff || out_ready;
      s1_ready  = !s1_valid_ff || s2_ready;
      req_xfer  = req_ch.valid && req_ch.ready;
      s1_move   = s1_valid_ff && s2_ready;
      s2_move   = s2_valid_ff && out_ready;
      is_frame  = (req_ch.opcode == OP_FRAME);

      step_sum = {1'b0, origin_ff} + {{(ORIGIN_W - 1){1'b0}}, req_ch.scroll_mode[1:0]};
      stepped  = (step_sum >= {1'b0, ORIGIN_MOD}) ? ORIGIN_W'(step_sum - {1'b0, ORIGIN_MOD})
                                                   : step_sum[ORIGIN_W-1:0];
      reseeded = (req_ch.reseed_value >= ORIGIN_MOD) ? req_ch.reseed_value - ORIGIN_MOD
                                                     : req_ch.reseed_value;
      origin_in = origin_ff;
      frame_in  = frame_ff;
      if (req_xfer && is_frame) begin
         origin_in = (req_ch.scroll_mode[2] && frame_ff == FRAME_LAST) ? reseeded : stepped;
         frame_in  = frame_ff + 1'b1;
      end

      addr_sum = {1'b0, origin_ff[ORIGIN_W-1:1]}
               + {1'b0, req_ch.pixel_y, 9'd0}
               + {10'd0, req_ch.pixel_x};
      addr_mod = (addr_sum >= {1'b0, STAR_PERIOD}) ? STAR_ADDR_W'(addr_sum - {1'b0, STAR_PERIOD})
                                                   : addr_sum[STAR_ADDR_W-1:0];

      s1_valid_in  = req_xfer || (s1_valid_ff && !s2_ready);
      s2_valid_in  = s1_move || (s2_valid_ff && !out_ready);
      out_valid_in = s2_move || (out_valid_ff && !rsp_ch.ready);

      rd_req.en   = s1_move;
      rd_req.addr = s1_addr_ff;

      star_hit = !s2_frame_ff && s2_par_ff && rd_data[ENTRY_W-1];
   end

   assign req_ch.ready = fill_done && s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff    <= '0;
         frame_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         origin_ff    <= origin_in;
         frame_ff     <= frame_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_addr_ff  <= addr_mod;
         s1_frame_ff <= is_frame;
         s1_par_ff   <= req_ch.pixel_y[0] ^ req_ch.pixel_x[3];
      end
      if (s1_move) begin
         s2_frame_ff <= s1_frame_ff;
         s2_par_ff   <= s1_par_ff;
      end
      if (s2_move) begin
         out_argb_ff <= star_hit ? colour_of(rd_data[5:0]) : 32'd0;
         out_vis_ff  <= star_hit;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.pixel_argb   = out_argb_ff;
   assign rsp_ch.star_visible = out_vis_ff;

endmodule

`default_nettype wire

FILE: tb/sv/starfield_pixel_checker.sv
// ----------------------------------------------------------------------------
// starfield_pixel_checker
// Watches the request and response channels of the starfield pixel source.
// Keeps its own star table, scroll origin and frame count, predicts the
// pixel for every request transfer and compares it field by field with the
// response transfers, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module starfield_pixel_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   lfsrsf_req_if       req_ch,
   lfsrsf_rsp_if       rsp_ch,
   output int unsigned mismatches,
   output int unsigned pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import lfsrsf_pkg::*;

   // intensity per 2-bit code, code 0 in the low byte
   localparam logic [31:0] LEVEL_WORD = {8'd255, 8'd214, 8'd194, 8'd0};

   typedef struct packed {
      logic [31:0] argb;
      logic        visible;
   } pixel_out_type;

   logic [ENTRY_W-1:0]  star_tab [0:STAR_PERIOD-1];
   logic [ORIGIN_W-1:0] origin;
   logic [5:0]          frames;
   pixel_out_type       expected_px [$];
   int unsigned         err_count   = 0;
   int unsigned         queue_depth = 0;

   assign mismatches = err_count;
   assign pending    = queue_depth;

   initial begin : fill_stars
      logic [STAR_ADDR_W-1:0] lfsr;
      lfsr = '0;
      for (int i = 0; i < int'(STAR_PERIOD); i++) begin
         star_tab[i] = {(lfsr & ENABLE_MASK) == ENABLE_MATCH, ~lfsr[8:3]};
         lfsr = {lfsr[12] ^ ~lfsr[0], lfsr[16:1]};
      end
   end

   function automatic logic [7:0] intensity(input logic hi, input logic lo);
      return LEVEL_WORD[int'({hi, lo}) * 8 +: 8];
   endfunction

   function automatic pixel_out_type predict_pixel(input logic [7:0] x, input logic [7:0] y);
      int unsigned        addr;
      logic [ENTRY_W-1:0] entry;
      pixel_out_type      px;
      addr  = (origin / 2 + 512 * y + x) % STAR_PERIOD;
      entry = star_tab[addr];
      px    = '0;
      if (entry[6] && (y[0] ^ x[3])) begin
         px.argb    = ALPHA_OPAQUE | {8'd0, intensity(entry[4], entry[5]),
                                      intensity(entry[2], entry[3]),
                                      intensity(entry[0], entry[1])};
         px.visible = 1'b1;
      end
      return px;
   endfunction

   task automatic advance_frame(input logic [2:0] mode, input logic [17:0] reseed);
      logic [ORIGIN_W:0] next;
      next = {1'b0, origin} + {{(ORIGIN_W - 1){1'b0}}, mode[1:0]};
      if (next >= ORIGIN_MOD) next -= ORIGIN_MOD;
      if (mode[2] && frames == FRAME_LAST) begin
         next = {1'b0, reseed};
         if (next >= ORIGIN_MOD) next -= ORIGIN_MOD;
      end
      origin = next[ORIGIN_W-1:0];
      frames = frames + 1'b1;
   endtask

   task automatic flag_error(input string msg);
      err_count++;
      if (err_count <= 10) $display("%0t ns: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      pixel_out_type want;
      if (reset) begin
         origin = '0;
         frames = '0;
         expected_px.delete();
      end else begin
         // a response can never belong to a request taken at the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_px.size() == 0) begin
               flag_error($sformatf("response with nothing outstanding: argb=%08h vis=%0b",
                                    rsp_ch.pixel_argb, rsp_ch.star_visible));
            end else begin
               want = expected_px.pop_front();
               if (want.argb !== rsp_ch.pixel_argb || want.visible !== rsp_ch.star_visible)
                  flag_error($sformatf("pixel mismatch: exp argb=%08h vis=%0b, got %08h %0b",
                                       want.argb, want.visible,
                                       rsp_ch.pixel_argb, rsp_ch.star_visible));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (opcode_type'(req_ch.opcode) == OP_FRAME) begin
               expected_px.push_back('0);
               advance_frame(req_ch.scroll_mode, req_ch.reseed_value);
            end else begin
               expected_px.push_back(predict_pixel(req_ch.pixel_x, req_ch.pixel_y));
            end
         end
      end
      queue_depth = expected_px.size();
   end

endmodule

`default_nettype wire

FILE: tb/sv/lfsr_starfield_pixel_generator_unit_tb.sv
// ----------------------------------------------------------------------------
// lfsr_starfield_pixel_generator_unit_tb
// Drives pixel and end-of-frame requests into the starfield pixel source with
// random gaps and response back-pressure, aims many pixels at known star
// locations, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsr_starfield_pixel_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lfsrsf_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1300;
   localparam int unsigned LIMIT_CYCLES = 1_500_000;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned DRAIN_CYCLES = 20;

   typedef struct {
      opcode_type  op;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [2:0]  mode;
      logic [17:0] reseed;
   } px_item_type;

   logic        clock;
   logic        reset;
   int unsigned mismatches;
   int unsigned pending;
   int unsigned cycles      = 0;
   int unsigned holds_asked = 0;
   int unsigned holds_done  = 0;
   bit          no_gaps     = 1'b0;
   int unsigned star_addrs [$];
   int unsigned origin_m    = 0;
   logic [5:0]  frames_m    = '0;

   lfsrsf_req_if pix_req ();
   lfsrsf_rsp_if pix_rsp ();

   lfsr_starfield_pixel_generator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (pix_req),
      .rsp_ch (pix_rsp)
   );

   starfield_pixel_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (pix_req),
      .rsp_ch     (pix_rsp),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(99, 0);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic int unsigned rand_line();
      if ($urandom_range(99, 0) < 85) return $urandom_range(223, 0);
      return $urandom_range(255, 224);
   endfunction

   function automatic px_item_type pixel_at(input int unsigned x, input int unsigned y);
      px_item_type it;
      it.op     = OP_PIXEL;
      it.x      = x[7:0];
      it.y      = y[7:0];
      it.mode   = 3'($urandom);
      it.reseed = 18'($urandom);
      return it;
   endfunction

   // pick a star and solve for (x,y) under the current origin
   function automatic px_item_type star_pixel();
      int unsigned d;
      d = 256;
      if (star_addrs.size() == 0) return pixel_at($urandom_range(255, 0), rand_line());
      for (int t = 0; t < 16 && d % 512 >= 256; t++)
         d = (star_addrs[$urandom_range(star_addrs.size() - 1, 0)] + STAR_PERIOD
              - origin_m / 2) % STAR_PERIOD;
      if (d % 512 >= 256) return pixel_at($urandom_range(255, 0), rand_line());
      return pixel_at(d % 512, d / 512);
   endfunction

   function automatic px_item_type frame_item(input logic [2:0] mode,
                                              input logic [17:0] reseed);
      px_item_type it;
      it.op     = OP_FRAME;
      it.x      = 8'($urandom);
      it.y      = 8'($urandom);
      it.mode   = mode;
      it.reseed = reseed;
      return it;
   endfunction

   function automatic px_item_type random_item();
      logic [2:0]  mode;
      logic [17:0] reseed;
      if ($urandom_range(99, 0) < 30) begin
         mode = 3'($urandom_range(7, 0));
         if (frames_m == FRAME_LAST && $urandom_range(3, 0) != 0) mode[2] = 1'b1;
         if ($urandom_range(2, 0) == 0) reseed = 18'($urandom_range(262143, 262136));
         else reseed = 18'($urandom_range(262143, 0));
         return frame_item(mode, reseed);
      end
      if ($urandom_range(99, 0) < 35) return star_pixel();
      return pixel_at($urandom_range(255, 0), rand_line());
   endfunction

   task automatic send_item(input px_item_type it);
      int unsigned gap;
      gap = no_gaps ? 0 : idle_cycles();
      if (gap != 0) begin
         pix_req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pix_req.valid        <= 1'b1;
      pix_req.opcode       <= it.op;
      pix_req.pixel_x      <= it.x;
      pix_req.pixel_y      <= it.y;
      pix_req.scroll_mode  <= it.mode;
      pix_req.reseed_value <= it.reseed;
      do @(posedge clock); while (!pix_req.ready);
      // origin tracking, only for aiming pixels at stars
      if (it.op == OP_FRAME) begin
         origin_m += it.mode[1:0];
         if (origin_m >= ORIGIN_MOD) origin_m -= ORIGIN_MOD;
         if (it.mode[2] && frames_m == FRAME_LAST) origin_m = it.reseed % ORIGIN_MOD;
         frames_m++;
      end
   endtask

   // response side back-pressure
   initial begin
      int unsigned n;
      forever begin
         if (holds_asked != holds_done) begin
            holds_done++;
            pix_rsp.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            n = idle_cycles();
            pix_rsp.ready <= (n == 0);
            repeat (n == 0 ? $urandom_range(30, 1) : n) @(posedge clock);
         end
      end
   end

   initial begin
      int unsigned            sent;
      logic [STAR_ADDR_W-1:0] lfsr;
      reset                <= 1'b1;
      pix_req.valid        <= 1'b0;
      pix_req.opcode       <= OP_PIXEL;
      pix_req.pixel_x      <= '0;
      pix_req.pixel_y      <= '0;
      pix_req.scroll_mode  <= '0;
      pix_req.reseed_value <= '0;

      // star locations for aimed pixels
      lfsr = '0;
      for (int i = 0; i < int'(STAR_PERIOD); i++) begin
         if ((lfsr & ENABLE_MASK) == ENABLE_MATCH) star_addrs.push_back(i);
         lfsr = {lfsr[12] ^ ~lfsr[0], lfsr[16:1]};
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, lines past 223, stripe parity, stars, every scroll mode
      send_item(pixel_at(0, 0));
      send_item(pixel_at(255, 0));
      send_item(pixel_at(0, 223));
      send_item(pixel_at(255, 223));
      send_item(pixel_at(0, 224));
      send_item(pixel_at(255, 255));
      send_item(pixel_at(8, 0));
      repeat (3) send_item(star_pixel());
      for (int m = 0; m < 8; m++)
         send_item(frame_item(m[2:0], m[0] ? 18'h3ffff : 18'h0));
      repeat (4) send_item(star_pixel());
      send_item(pixel_at(128, 1));
      send_item(pixel_at(7, 255));

      for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
         if (sent % 50 == 0) no_gaps = ($urandom_range(3, 0) == 0);
         if (sent == 300) begin
            holds_asked++;
            no_gaps = 1'b1;
         end
         if (sent == 340) no_gaps = 1'b0;
         if (sent == 650) begin
            pix_req.valid <= 1'b0;
            @(posedge clock);
            wait (pending == 0);
         end
         send_item(random_item());
      end

      pix_req.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

FILE: lfsr_starfield_pixel_generator_unit.f
rtl/core/lfsrsf_pkg.sv
rtl/core/lfsrsf_channels.sv
rtl/core/lfsrsf_star_table.sv
rtl/core/lfsr_starfield_pixel_generator_unit.sv
tb/sv/starfield_pixel_checker.sv
tb/sv/lfsr_starfield_pixel_generator_unit_tb.sv
